@@ hw/rtl/hdlc_like_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// hdlc_like_frame_receiver_macros
// Assertion helpers shared by the frame receiver RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising
// edge of clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef HDLC_LIKE_FRAME_RECEIVER_MACROS_SVH
`define HDLC_LIKE_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define HLFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HLFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/hlfr_pkg.sv @@
// ----------------------------------------------------------------------------
// hlfr_pkg
// Types, codes and helper functions of the flag-delimited frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_FLAG = 3'd1,
      PH_ADDR = 3'd2,
      PH_CTRL = 3'd3,
      PH_BODY = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE = 3'd0,
      EV_OK   = 3'd1,
      EV_DUP  = 3'd2,
      EV_REJ  = 3'd3,
      EV_HDR  = 3'd4,
      EV_PAY  = 3'd5
   } event_type;

   localparam logic [1:0] CMD_BYTE     = 2'd0;
   localparam logic [1:0] CMD_RESTART  = 2'd1;
   localparam logic [1:0] CMD_LOAD_SEQ = 2'd2;

   localparam logic [1:0] MODE_SUPERVISION = 2'd0;
   localparam logic [1:0] MODE_WRITE_ACK   = 2'd1;
   localparam logic [1:0] MODE_READ_INFO   = 2'd2;

   localparam logic [1:0] REG_LINK_MODE        = 2'd0;
   localparam logic [1:0] REG_EXPECTED_ADDRESS = 2'd1;
   localparam logic [1:0] REG_EXPECTED_CONTROL = 2'd2;
   localparam logic [1:0] REG_FLAG_BYTE        = 2'd3;

   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] ESC_XOR  = 8'h20;

   localparam logic [1:0] LINK_MODE_RESET        = MODE_SUPERVISION;
   localparam logic [7:0] EXPECTED_ADDRESS_RESET = 8'h03;
   localparam logic [7:0] EXPECTED_CONTROL_RESET = 8'h00;
   localparam logic [7:0] FLAG_BYTE_RESET        = 8'h7E;

   // Information frame control code for sequence bit n.
   function automatic logic [7:0] info_code(input logic n);
      return {1'b0, n, 6'b000000};
   endfunction

   // Reject control code for sequence bit n.
   function automatic logic [7:0] rej_code(input logic n);
      return {n, 6'b000000, 1'b1};
   endfunction

endpackage

@@ hw/rtl/hdlc_like_frame_receiver.sv @@
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one input byte per cycle; the only stall is a full result
// register whose beat the consumer is itself stalling.
// Reset is synchronous and active high: the receiver hunts for a start flag,
// the sequence bit is zero and the registers take their documented defaults.
// ----------------------------------------------------------------------------
// hdlc_like_frame_receiver
// Byte-wise receiver for flag-delimited frames with an address/control header,
// an XOR header check, byte destuffing and an XOR payload check byte.
// ----------------------------------------------------------------------------
`include "hdlc_like_frame_receiver_macros.svh"

module hdlc_like_frame_receiver (
   input  logic                clock,
   input  logic                reset,
   // Input channel: one command beat per item.
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_seq_value,
   // Result channel: one result beat per input beat.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_data_valid,
   output logic [7:0]          rsp_data_byte,
   output hlfr_pkg::event_type rsp_frame_event,
   // Configuration write channel.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   import hlfr_pkg::*;

   // Configuration registers. Writes are always taken.
   logic [1:0] link_mode_ff;
   logic [7:0] expected_address_ff;
   logic [7:0] expected_control_ff;
   logic [7:0] flag_byte_ff;

   // Receiver state. held_byte_ff is only read while held_valid_ff is set,
   // so it carries no reset.
   phase_type  phase_ff, phase_in;
   logic       seq_bit_ff, seq_bit_in;
   logic [7:0] header_address_ff, header_address_in;
   logic [7:0] header_control_ff, header_control_in;
   logic       duplicate_mark_ff, duplicate_mark_in;
   logic       escape_pending_ff, escape_pending_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] running_xor_ff, running_xor_in;

   // Result register. It parts the two channels: a new beat is accepted in the
   // same cycle that the waiting result leaves.
   logic       rsp_valid_ff;
   logic       rsp_data_valid_ff, rsp_data_valid_in;
   logic [7:0] rsp_data_byte_ff, rsp_data_byte_in;
   event_type  rsp_frame_event_ff, rsp_frame_event_in;

   logic       req_fire;
   logic       byte_fire;
   logic       mode_rd;
   logic       mode_wr;
   logic [7:0] rx_destuffed;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign byte_fire = req_fire && (req_cmd == CMD_BYTE);

   assign mode_rd = (link_mode_ff == MODE_READ_INFO);
   assign mode_wr = (link_mode_ff == MODE_WRITE_ACK);

   // Destuffed value of the incoming byte when it follows an escape.
   assign rx_destuffed = escape_pending_ff ? (req_rx_byte ^ ESC_XOR) : req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_mode_ff        <= LINK_MODE_RESET;
         expected_address_ff <= EXPECTED_ADDRESS_RESET;
         expected_control_ff <= EXPECTED_CONTROL_RESET;
         flag_byte_ff        <= FLAG_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LINK_MODE:        link_mode_ff        <= csr_wdata[1:0];
            REG_EXPECTED_ADDRESS: expected_address_ff <= csr_wdata;
            REG_EXPECTED_CONTROL: expected_control_ff <= csr_wdata;
            REG_FLAG_BYTE:        flag_byte_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next-state logic. Every error path returns to the hunt with the per-frame
   // state cleared; the sequence bit and the stored header survive.
   always_comb begin
      phase_in          = phase_ff;
      seq_bit_in        = seq_bit_ff;
      header_address_in = header_address_ff;
      header_control_in = header_control_ff;
      duplicate_mark_in = duplicate_mark_ff;
      escape_pending_in = escape_pending_ff;
      held_byte_in      = held_byte_ff;
      held_valid_in     = held_valid_ff;
      running_xor_in    = running_xor_ff;

      if (req_fire && (req_cmd == CMD_RESTART)) begin
         phase_in          = PH_HUNT;
         duplicate_mark_in = 1'b0;
         escape_pending_in = 1'b0;
         held_valid_in     = 1'b0;
         running_xor_in    = '0;
      end else if (req_fire && (req_cmd == CMD_LOAD_SEQ)) begin
         seq_bit_in = req_seq_value;
      end else if (byte_fire) begin
         case (phase_ff)
            PH_FLAG: begin
               if (req_rx_byte == expected_address_ff) begin
                  phase_in          = PH_ADDR;
                  header_address_in = req_rx_byte;
               end else if (req_rx_byte != flag_byte_ff) begin
                  phase_in          = PH_HUNT;
                  duplicate_mark_in = 1'b0;
               end
            end
            PH_ADDR: begin
               if (mode_wr && (req_rx_byte == rej_code(!seq_bit_ff))) begin
                  phase_in          = PH_HUNT;
                  duplicate_mark_in = 1'b0;
               end else if (mode_rd && (req_rx_byte == info_code(!seq_bit_ff))) begin
                  duplicate_mark_in = 1'b1;
                  header_control_in = req_rx_byte;
                  phase_in          = PH_CTRL;
               end else if (req_rx_byte == expected_control_ff) begin
                  duplicate_mark_in = 1'b0;
                  header_control_in = req_rx_byte;
                  phase_in          = PH_CTRL;
               end else if (req_rx_byte == flag_byte_ff) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in          = PH_HUNT;
                  duplicate_mark_in = 1'b0;
               end
            end
            PH_CTRL: begin
               if (req_rx_byte == (header_address_ff ^ header_control_ff)) begin
                  if (mode_rd && duplicate_mark_ff) begin
                     phase_in          = PH_HUNT;
                     duplicate_mark_in = 1'b0;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end else if (req_rx_byte == flag_byte_ff) begin
                  phase_in          = PH_FLAG;
                  duplicate_mark_in = 1'b0;
               end else begin
                  phase_in          = PH_HUNT;
                  duplicate_mark_in = 1'b0;
               end
            end
            PH_BODY: begin
               if (!mode_rd) begin
                  if (req_rx_byte == flag_byte_ff) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in          = PH_HUNT;
                     duplicate_mark_in = 1'b0;
                  end
               end else if (req_rx_byte == flag_byte_ff) begin
                  // Closing flag: the held byte is the check byte.
                  if (held_valid_ff && !escape_pending_ff &&
                      (running_xor_ff == held_byte_ff)) begin
                     seq_bit_in = !seq_bit_ff;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in          = PH_HUNT;
                     duplicate_mark_in = 1'b0;
                  end
                  escape_pending_in = 1'b0;
                  held_valid_in     = 1'b0;
                  running_xor_in    = '0;
               end else if (!escape_pending_ff && (req_rx_byte == ESC_BYTE)) begin
                  escape_pending_in = 1'b1;
               end else begin
                  escape_pending_in = 1'b0;
                  if (held_valid_ff) begin
                     running_xor_in = running_xor_ff ^ held_byte_ff;
                  end
                  held_byte_in  = rx_destuffed;
                  held_valid_in = 1'b1;
               end
            end
            PH_DONE: ;
            default: begin
               // Hunting: a flag opens a new frame.
               if (req_rx_byte == flag_byte_ff) begin
                  phase_in          = PH_FLAG;
                  duplicate_mark_in = 1'b0;
                  escape_pending_in = 1'b0;
                  held_valid_in     = 1'b0;
                  running_xor_in    = '0;
               end
            end
         endcase
      end
   end

   // Result logic for the accepted beat.
   always_comb begin
      rsp_data_valid_in  = 1'b0;
      rsp_data_byte_in   = '0;
      rsp_frame_event_in = EV_NONE;

      if (byte_fire) begin
         case (phase_ff)
            PH_ADDR: begin
               if (mode_wr && (req_rx_byte == rej_code(!seq_bit_ff))) begin
                  rsp_frame_event_in = EV_REJ;
               end
            end
            PH_CTRL: begin
               if (req_rx_byte == (header_address_ff ^ header_control_ff)) begin
                  if (mode_rd && duplicate_mark_ff) begin
                     rsp_frame_event_in = EV_DUP;
                  end
               end else if (req_rx_byte != flag_byte_ff) begin
                  if (mode_rd || mode_wr) begin
                     rsp_frame_event_in = EV_HDR;
                  end
               end
            end
            PH_BODY: begin
               if (!mode_rd) begin
                  if (req_rx_byte == flag_byte_ff) begin
                     rsp_frame_event_in = EV_OK;
                  end
               end else if (req_rx_byte == flag_byte_ff) begin
                  if (held_valid_ff && !escape_pending_ff &&
                      (running_xor_ff == held_byte_ff)) begin
                     rsp_frame_event_in = EV_OK;
                  end else begin
                     rsp_frame_event_in = EV_PAY;
                  end
               end else if (!(!escape_pending_ff && (req_rx_byte == ESC_BYTE))) begin
                  // A completed payload byte pushes out the previously held one.
                  if (held_valid_ff) begin
                     rsp_data_valid_in = 1'b1;
                     rsp_data_byte_in  = held_byte_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         seq_bit_ff        <= 1'b0;
         header_address_ff <= '0;
         header_control_ff <= '0;
         duplicate_mark_ff <= 1'b0;
         escape_pending_ff <= 1'b0;
         held_valid_ff     <= 1'b0;
         running_xor_ff    <= '0;
      end else begin
         phase_ff          <= phase_in;
         seq_bit_ff        <= seq_bit_in;
         header_address_ff <= header_address_in;
         header_control_ff <= header_control_in;
         duplicate_mark_ff <= duplicate_mark_in;
         escape_pending_ff <= escape_pending_in;
         held_valid_ff     <= held_valid_in;
         running_xor_ff    <= running_xor_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

   // Result register: loads on every accepted beat, empties when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_valid_ff  <= rsp_data_valid_in;
         rsp_data_byte_ff   <= rsp_data_byte_in;
         rsp_frame_event_ff <= rsp_frame_event_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_valid  = rsp_data_valid_ff;
   assign rsp_data_byte   = rsp_data_byte_ff;
   assign rsp_frame_event = rsp_frame_event_ff;

   // A payload byte and a frame event never share one result.
   `HLFR_ASSERT_NOW(a_data_no_event, rsp_valid_ff && rsp_data_valid_ff, rsp_frame_event_ff == EV_NONE, "payload byte carried a frame event")
   // While a header is being read, no payload state is left over.
   `HLFR_ASSERT_NOW(a_header_state_clear, (phase_ff == PH_FLAG) || (phase_ff == PH_ADDR) || (phase_ff == PH_CTRL), !held_valid_ff && !escape_pending_ff && (running_xor_ff == 8'h00), "payload state left during header")
   // A restart always leaves the receiver hunting with a clear check.
   `HLFR_ASSERT_NEXT(a_restart_hunts, req_fire && (req_cmd == CMD_RESTART), (phase_ff == PH_HUNT) && (running_xor_ff == 8'h00), "restart did not return to hunt")
   // A good read frame toggles the sequence bit.
   `HLFR_ASSERT_NEXT(a_ok_toggles_seq, byte_fire && mode_rd && (rsp_frame_event_in == EV_OK), seq_bit_ff != $past(seq_bit_ff), "read frame ok without sequence toggle")

endmodule

@@ sim/hlfr_checker.sv @@
// ----------------------------------------------------------------------------
// hlfr_checker
// Scoreboard for the flag-delimited frame receiver. It watches the request,
// result and register channels, predicts each result beat from its own copy
// of the receiver state and compares every field against the DUT.
// ----------------------------------------------------------------------------
module hlfr_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_seq_value,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_data_valid,
   input  logic [7:0]          rsp_data_byte,
   input  hlfr_pkg::event_type rsp_frame_event,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output int                  pending,
   output int                  failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import hlfr_pkg::*;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      event_type  frame_event;
   } rx_result_type;

   rx_result_type result_q [$];
   int            err_count;

   // Register copies.
   logic [1:0] cfg_mode;
   logic [7:0] cfg_addr;
   logic [7:0] cfg_ctrl;
   logic [7:0] cfg_flag;

   // Receiver state copies.
   phase_type  st_phase;
   logic       st_seq;
   logic [7:0] st_addr;
   logic [7:0] st_ctrl;
   logic       st_dup;
   logic       st_esc;
   logic [7:0] st_held;
   logic       st_held_ok;
   logic [7:0] st_xor;

   function automatic void return_to_hunt();
      st_phase   = PH_HUNT;
      st_dup     = 1'b0;
      st_esc     = 1'b0;
      st_held_ok = 1'b0;
      st_xor     = 8'h00;
   endfunction

   // Advances the state copy by one beat and returns the result it produces.
   function automatic rx_result_type decode_beat(input logic [1:0] cmd, input logic [7:0] b,
                                                 input logic seq_in);
      rx_result_type r;
      logic          rd;
      logic          wr;
      logic [7:0]    d;
      r  = '{1'b0, 8'h00, EV_NONE};
      rd = (cfg_mode == MODE_READ_INFO);
      wr = (cfg_mode == MODE_WRITE_ACK);
      case (cmd)
         CMD_RESTART: return_to_hunt();
         CMD_LOAD_SEQ: st_seq = seq_in;
         CMD_BYTE: begin
            case (st_phase)
               PH_FLAG: begin
                  if (b == cfg_addr) begin
                     st_phase = PH_ADDR;
                     st_addr  = b;
                  end else if (b != cfg_flag) begin
                     return_to_hunt();
                  end
               end
               PH_ADDR: begin
                  if (wr && b == {~st_seq, 6'd0, 1'b1}) begin
                     r.frame_event = EV_REJ;
                     return_to_hunt();
                  end else if (rd && b == {1'b0, ~st_seq, 6'd0}) begin
                     st_dup   = 1'b1;
                     st_ctrl  = b;
                     st_phase = PH_CTRL;
                  end else if (b == cfg_ctrl) begin
                     st_dup   = 1'b0;
                     st_ctrl  = b;
                     st_phase = PH_CTRL;
                  end else if (b == cfg_flag) begin
                     st_phase = PH_FLAG;
                  end else begin
                     return_to_hunt();
                  end
               end
               PH_CTRL: begin
                  if (b == (st_addr ^ st_ctrl)) begin
                     if (rd && st_dup) begin
                        r.frame_event = EV_DUP;
                        return_to_hunt();
                     end else begin
                        st_phase   = PH_BODY;
                        st_esc     = 1'b0;
                        st_held_ok = 1'b0;
                        st_xor     = 8'h00;
                     end
                  end else if (b == cfg_flag) begin
                     st_phase = PH_FLAG;
                     st_dup   = 1'b0;
                  end else begin
                     if (rd || wr) r.frame_event = EV_HDR;
                     return_to_hunt();
                  end
               end
               PH_BODY: begin
                  if (!rd) begin
                     if (b == cfg_flag) begin
                        st_phase      = PH_DONE;
                        r.frame_event = EV_OK;
                     end else begin
                        return_to_hunt();
                     end
                  end else if (b == cfg_flag) begin
                     if (st_held_ok && !st_esc && st_xor == st_held) begin
                        st_seq        = ~st_seq;
                        r.frame_event = EV_OK;
                        st_phase      = PH_DONE;
                        st_esc        = 1'b0;
                        st_held_ok    = 1'b0;
                        st_xor        = 8'h00;
                     end else begin
                        r.frame_event = EV_PAY;
                        return_to_hunt();
                     end
                  end else if (!st_esc && b == ESC_BYTE) begin
                     st_esc = 1'b1;
                  end else begin
                     d      = st_esc ? (b ^ ESC_XOR) : b;
                     st_esc = 1'b0;
                     if (st_held_ok) begin
                        r.data_valid = 1'b1;
                        r.data_byte  = st_held;
                        st_xor       = st_xor ^ st_held;
                     end
                     st_held    = d;
                     st_held_ok = 1'b1;
                  end
               end
               PH_DONE: ;
               default: begin
                  if (b == cfg_flag) begin
                     return_to_hunt();
                     st_phase = PH_FLAG;
                  end
               end
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rx_result_type want;
      if (reset) begin
         cfg_mode = LINK_MODE_RESET;
         cfg_addr = EXPECTED_ADDRESS_RESET;
         cfg_ctrl = EXPECTED_CONTROL_RESET;
         cfg_flag = FLAG_BYTE_RESET;
         st_seq   = 1'b0;
         st_addr  = 8'h00;
         st_ctrl  = 8'h00;
         st_held  = 8'h00;
         return_to_hunt();
         result_q.delete();
         err_count = 0;
         pending  <= 0;
         failures <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LINK_MODE:        cfg_mode = csr_wdata[1:0];
               REG_EXPECTED_ADDRESS: cfg_addr = csr_wdata;
               REG_EXPECTED_CONTROL: cfg_ctrl = csr_wdata;
               REG_FLAG_BYTE:        cfg_flag = csr_wdata;
               default: ;
            endcase
         end
         // A result beat always belongs to an earlier request beat, so the
         // comparison runs before this edge's prediction is queued.
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("result beat arrived with no expectation waiting");
               err_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_data_valid !== want.data_valid) begin
                  $error("data_valid mismatch: expected %0d, actual %0d",
                         want.data_valid, rsp_data_valid);
                  err_count++;
               end
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want.data_byte, rsp_data_byte);
                  err_count++;
               end
               if (rsp_frame_event !== want.frame_event) begin
                  $error("frame_event mismatch: expected %0d, actual %0d",
                         want.frame_event, rsp_frame_event);
                  err_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            result_q.push_back(decode_beat(req_cmd, req_rx_byte, req_seq_value));
         end
         pending  <= result_q.size();
         failures <= err_count;
      end
   end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the flag-delimited frame receiver. A short directed
// run is followed by randomized phases of mostly well-formed frames under
// several register settings, with random idling on both channels and one
// long back-pressure stretch. Checking is done by hlfr_checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hlfr_pkg::*;

   // Link mode code that the receiver treats as supervision.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Command code that the receiver ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // Generous ceiling on the run, used by the watchdog.
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_BEATS = 38;
   localparam int RANDOM_PHASES = 10;
   localparam int SQUEEZE_CYCLES = 120;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic       seq_value;
   } line_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd = CMD_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_seq_value = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   event_type  rsp_frame_event;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = REG_LINK_MODE;
   logic [7:0] csr_wdata = 8'h00;
   int         pending;
   int         failures;
   int         cycle_count;

   // Beats waiting to be offered on the request channel.
   line_beat_type beat_q [$];

   // Register values currently programmed; the frame builder uses them.
   logic [1:0] cur_mode = LINK_MODE_RESET;
   logic [7:0] cur_addr = EXPECTED_ADDRESS_RESET;
   logic [7:0] cur_ctrl = EXPECTED_CONTROL_RESET;
   logic [7:0] cur_flag = FLAG_BYTE_RESET;

   // Idling modes. While squeeze is set the sender never idles and the
   // receiver holds off for long stretches, so the result path backs up.
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   bit squeeze = 1'b0;

   always #5 clock = ~clock;

   hdlc_like_frame_receiver u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .req_seq_value   (req_seq_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_event (rsp_frame_event),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   hlfr_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .req_seq_value   (req_seq_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_event (rsp_frame_event),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending         (pending),
      .failures        (failures)
   );

   function automatic logic coin();
      return 1'($urandom);
   endfunction

   function automatic void add_beat(input logic [1:0] cmd, input logic [7:0] b,
                                    input logic sv);
      beat_q.push_back('{cmd, b, sv});
   endfunction

   // A byte beat; the unused seq_value input gets random content.
   function automatic void add_byte(input logic [7:0] b);
      add_beat(CMD_BYTE, b, coin());
   endfunction

   // Writes one register. Valid stays high so that back-to-back writes do not
   // lower and raise it in the same time step; program_link lowers it.
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Programs all four registers. Only called while the receiver is idle.
   task automatic program_link(input logic [1:0] mode, input logic [7:0] addr,
                               input logic [7:0] ctrl, input logic [7:0] flag);
      write_reg(REG_LINK_MODE, {6'd0, mode});
      write_reg(REG_EXPECTED_ADDRESS, addr);
      write_reg(REG_EXPECTED_CONTROL, ctrl);
      write_reg(REG_FLAG_BYTE, flag);
      csr_valid <= 1'b0;
      cur_mode = mode;
      cur_addr = addr;
      cur_ctrl = ctrl;
      cur_flag = flag;
   endtask

   // Offers every queued beat in turn. Each beat draws its own idle gap, and
   // valid is only dropped when there really is a gap to wait out.
   task automatic send_beats();
      line_beat_type bt;
      int            gap;
      while (beat_q.size() != 0) begin
         bt = beat_q.pop_front();
         if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
         gap = (tx_burst || squeeze) ? 0 : $urandom_range(0, 18);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_cmd       <= bt.cmd;
         req_rx_byte   <= bt.rx_byte;
         req_seq_value <= bt.seq_value;
         do @(posedge clock); while (req_stall);
      end
   endtask

   // Every beat yields exactly one result in the cycle after it is accepted, so
   // the receiver is idle once the checker holds no expectation. The checker's
   // count is registered, hence the wait before it is trusted.
   task automatic wait_idle();
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic run_phase();
      send_beats();
      req_valid <= 1'b0;
      wait_idle();
   endtask

   // Builds one frame for the current mode. Most frames are well formed;
   // each field has a small chance of being wrong so that every error path
   // and the early-flag restarts are reached.
   task automatic add_frame();
      logic       s;
      logic [7:0] addr;
      logic [7:0] ctrl;
      logic [7:0] chk;
      logic [7:0] d;
      logic [7:0] body [$];
      int         len;
      if ($urandom_range(0, 3) != 0) add_beat(CMD_RESTART, 8'($urandom), coin());
      // In read mode the sequence bit that makes the expected control an
      // in-sequence information frame is bit 6 of that control.
      s = (cur_mode == MODE_READ_INFO) ? cur_ctrl[6] : coin();
      if ($urandom_range(0, 4) != 0) add_beat(CMD_LOAD_SEQ, 8'($urandom), s);
      add_byte(cur_flag);
      if ($urandom_range(0, 7) == 0) add_byte(cur_flag);
      addr = ($urandom_range(0, 7) != 0) ? cur_addr : 8'($urandom);
      add_byte(addr);
      case ($urandom_range(0, 9))
         5: ctrl = {1'b0, s, 6'd0};
         6: ctrl = {1'b0, ~s, 6'd0};
         7: ctrl = {~s, 6'd0, 1'b1};
         8: ctrl = {s, 6'd0, 1'b1};
         9: ctrl = 8'($urandom);
         default: ctrl = cur_ctrl;
      endcase
      add_byte(ctrl);
      case ($urandom_range(0, 9))
         8: add_byte(cur_flag);
         9: add_byte(8'($urandom));
         default: add_byte(addr ^ ctrl);
      endcase
      if (cur_mode == MODE_READ_INFO) begin
         // Payload bytes lean toward the flag and escape values so that
         // stuffing is exercised, followed by the XOR check byte.
         if ($urandom_range(0, 9) != 0) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
            chk = 8'h00;
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 7))
                  0: d = cur_flag;
                  1: d = ESC_BYTE;
                  2: d = cur_flag ^ ESC_XOR;
                  default: d = 8'($urandom);
               endcase
               body.push_back(d);
               chk = chk ^ d;
            end
            if ($urandom_range(0, 7) == 0) chk = chk ^ 8'(1 << $urandom_range(0, 7));
            body.push_back(chk);
            foreach (body[i]) begin
               if (body[i] == cur_flag || body[i] == ESC_BYTE) begin
                  add_byte(ESC_BYTE);
                  add_byte(body[i] ^ ESC_XOR);
               end else begin
                  add_byte(body[i]);
               end
            end
         end
         // A dangling escape right before the closing flag.
         if ($urandom_range(0, 9) == 0) add_byte(ESC_BYTE);
      end else if ($urandom_range(0, 5) == 0) begin
         add_byte(8'($urandom));
      end
      if ($urandom_range(0, 9) != 0) add_byte(cur_flag);
      // Bytes after a completed frame must be ignored until a restart.
      if ($urandom_range(0, 2) == 0) add_byte(8'($urandom));
   endtask

   // Line noise: arbitrary commands, including the unused code, and bytes.
   task automatic add_noise();
      repeat ($urandom_range(1, 6)) add_beat(2'($urandom), 8'($urandom), coin());
   endtask

   // Result side. Each beat draws a hold-off; while squeeze is set the
   // hold-off is long enough to fill the receiver and stall its input.
   initial begin : consumer
      int n;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         n = squeeze ? SQUEEZE_CYCLES : (rx_burst ? 0 : $urandom_range(0, 18));
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: a hung handshake or a result that never arrives ends here.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("hdlc_like_frame_receiver test failed");
      $finish;
   end

   initial begin : stimulus
      logic [1:0] m;
      logic [7:0] c;
      logic [7:0] f;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values (supervision, address 0x03,
      // control 0x00, flag 0x7E). The unused command must produce no event,
      // a good supervision frame completes, a byte after it is ignored, and
      // a bad header check drops back to the hunt silently.
      add_beat(CMD_UNUSED, 8'hFF, 1'b1);
      add_byte(8'h7E);
      add_byte(8'h03);
      add_byte(8'h00);
      add_byte(8'h03);
      add_byte(8'h7E);
      add_byte(8'hFF);
      add_beat(CMD_RESTART, 8'h00, 1'b0);
      add_byte(8'h7E);
      add_byte(8'h03);
      add_byte(8'h00);
      add_byte(8'h55);
      run_phase();

      // Directed, write acknowledge: a reject carrying the other sequence
      // bit is reported.
      program_link(MODE_WRITE_ACK, 8'hFF, 8'h00, FLAG_BYTE_RESET);
      add_beat(CMD_LOAD_SEQ, 8'h00, 1'b1);
      add_byte(8'h7E);
      add_byte(8'hFF);
      add_byte(8'h01);
      run_phase();

      // Directed, read mode: a frame whose payload and check byte are both
      // escaped, then a repeat of the same sequence reported as a duplicate.
      program_link(MODE_READ_INFO, 8'h00, 8'h00, FLAG_BYTE_RESET);
      add_beat(CMD_LOAD_SEQ, 8'hFF, 1'b0);
      add_byte(8'h7E);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(ESC_BYTE);
      add_byte(ESC_BYTE ^ ESC_XOR);
      add_byte(ESC_BYTE);
      add_byte(ESC_BYTE ^ ESC_XOR);
      add_byte(8'h7E);
      add_beat(CMD_RESTART, 8'hFF, 1'b1);
      add_byte(8'h7E);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h00);
      run_phase();

      // Random phases. The first two use the extreme register values, the
      // next three pin one mode each, and the rest are drawn with read mode
      // favored since it has the deepest behavior.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_link(MODE_SUPERVISION, 8'h00, 8'h00, 8'h00);
            1: program_link(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF);
            2: program_link(MODE_READ_INFO, 8'($urandom), 8'h00, FLAG_BYTE_RESET);
            3: program_link(MODE_READ_INFO, 8'($urandom), 8'h40, FLAG_BYTE_RESET);
            4: program_link(MODE_WRITE_ACK, 8'($urandom), 8'($urandom), FLAG_BYTE_RESET);
            default: begin
               m = ($urandom_range(0, 2) == 0) ? 2'($urandom) : MODE_READ_INFO;
               if (m == MODE_READ_INFO && $urandom_range(0, 3) != 0) begin
                  c = {1'b0, coin(), 6'd0};
               end else begin
                  c = 8'($urandom);
               end
               f = ($urandom_range(0, 2) != 0) ? FLAG_BYTE_RESET : 8'($urandom);
               program_link(m, 8'($urandom), c, f);
            end
         endcase
         while (beat_q.size() < PHASE_BEATS) begin
            if ($urandom_range(0, 5) == 0) begin
               add_noise();
            end else begin
               add_frame();
            end
         end
         // One read phase runs under heavy back-pressure.
         squeeze = (p == 3);
         run_phase();
         squeeze = 1'b0;
      end

      // Let the last results settle before the verdict.
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("hdlc_like_frame_receiver test passed");
      end else begin
         $display("hdlc_like_frame_receiver test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/hlfr_pkg.sv
hw/rtl/hdlc_like_frame_receiver.sv
sim/hlfr_checker.sv
sim/tb_top.sv
